@@ rtl/core/mfbde_pkg.sv @@
// Shared types, constants and codes for the monochrome framebuffer draw engine.
`timescale 1ns / 1ps

package mfbde_pkg;

   // Default panel geometry
   localparam int PANEL_WIDTH_DEF  = 128;
   localparam int PANEL_HEIGHT_DEF = 64;

   // Field widths
   localparam int OP_W    = 3;
   localparam int COORD_W = 8;

   // Slope arithmetic: dy*10 fits in 12 bits, remainders of tenths in 4
   localparam int SLOPE_SCALE = 10;
   localparam int DIV_W       = 12;
   localparam int DIV_CNT_W   = $clog2(DIV_W);
   localparam int TENTH_W     = 4;

   // One tenth in 16 fractional bits; exact floor for dividends below 16384
   localparam int TENTH_RECIP = 6554;
   localparam int TENTH_SHIFT = 16;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_SET_POINT   = 3'd0,
      OP_CLEAR_POINT = 3'd1,
      OP_LINE        = 3'd2,
      OP_CIRCLE      = 3'd3,
      OP_CLEAR_ALL   = 3'd4,
      OP_READ_BYTE   = 3'd5
   } op_type;

   // Engine sequencer states
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_DIV_K,
      S_DIV_T,
      S_CIR_TEST,
      S_CIR_STEP,
      S_PIX,
      S_WRITE,
      S_RDWAIT,
      S_DONE
   } state_type;

   // What the pixel walker is drawing
   typedef enum logic [2:0] {
      KIND_SET,
      KIND_CLR,
      KIND_VERT,
      KIND_HORZ,
      KIND_DIAG,
      KIND_CIRC
   } kind_type;

   // Divider request and response
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

@@ rtl/core/mfbde_req_if.sv @@
// Request channel interface: one draw or read operation per transaction.
`timescale 1ns / 1ps

interface mfbde_req_if;
   import mfbde_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [COORD_W-1:0] x;
   logic [COORD_W-1:0] y;
   logic [COORD_W-1:0] x_end;
   logic [COORD_W-1:0] y_end;
   logic [COORD_W-1:0] radius;

   modport source (output valid, op, x, y, x_end, y_end, radius, input ready);
   modport sink   (input valid, op, x, y, x_end, y_end, radius, output ready);
endinterface

@@ rtl/core/mfbde_rsp_if.sv @@
// Response channel interface: status and read byte, one transaction per request.
`timescale 1ns / 1ps

interface mfbde_rsp_if;
   import mfbde_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic [COORD_W-1:0] read_data;

   modport source (output valid, status, read_data, input ready);
   modport sink   (input valid, status, read_data, output ready);
endinterface

@@ rtl/core/mfbde_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the line slope.
`timescale 1ns / 1ps

module mfbde_div (
   input  logic                    clock,
   input  logic                    reset,
   input  mfbde_pkg::div_req_type  div_req,
   output mfbde_pkg::div_rsp_type  div_rsp
);
   import mfbde_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       diff;
   logic                 fits;

   // Trial subtract of the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   // Load on start, then shift in one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff;

   // Start only when no division is running
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // Done follows a running division
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a division");

   // Final remainder is below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < den_ff)
      else $error("divider remainder out of range");

endmodule

@@ rtl/core/mono_framebuffer_draw_engine.sv @@
// Top level: page framebuffer memory with point, line, circle, clear and read.
// Each plotted pixel is read and then written back; a line skips pixels off the panel, a
// diagonal line first divides for its slope, and a circle mirrors each step into all octants.
// Clear all zeroes PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes (1024 by default), one byte at a time.
// Throughput: one item at a time, bounded by read-modify-write through the one memory write port.
// Reset runs the same clearing pass with req_ch.ready low.
`timescale 1ns / 1ps

module mono_framebuffer_draw_engine #(
   parameter int PANEL_WIDTH  = mfbde_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = mfbde_pkg::PANEL_HEIGHT_DEF
) (
   input  logic   clock,
   input  logic   reset,
   mfbde_req_if.sink   req_ch,
   mfbde_rsp_if.source rsp_ch
);
   import mfbde_pkg::*;

   localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_DEPTH = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Frame memory
   logic [COORD_W-1:0] frame_mem [STORE_DEPTH];
   logic [COORD_W-1:0] mem_rdata_ff;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [COORD_W-1:0] mem_wdata;
   logic               mem_we;

   // Sequencer and walker registers
   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [COORD_W-1:0]  x0_ff, x0_in;
   logic [COORD_W-1:0]  y0_ff, y0_in;
   logic [COORD_W-1:0]  cnt_ff, cnt_in;
   logic [COORD_W-1:0]  len_ff, len_in;
   logic [COORD_W-1:0]  q_ff, q_in;
   logic [TENTH_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]    k_ff, k_in;
   logic [COORD_W-1:0]  kq_ff, kq_in;
   logic [TENTH_W-1:0]  kr_ff, kr_in;
   logic [COORD_W-1:0]  a_ff, a_in;
   logic [COORD_W-1:0]  b_ff, b_in;
   logic [15:0]         aa_ff, aa_in;
   logic [15:0]         bb_ff, bb_in;
   logic [15:0]         rr_ff, rr_in;
   logic [2:0]          oct_ff, oct_in;
   logic [ADDR_W-1:0]   pix_addr_ff, pix_addr_in;
   logic [2:0]          pix_bit_ff, pix_bit_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                st_ff, st_in;
   logic [COORD_W-1:0]  rd_ff, rd_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [COORD_W-1:0]  rsp_data_ff, rsp_data_in;

   // Combinational helpers
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic [COORD_W-1:0]  pix_x, pix_y;
   logic                pix_on;
   logic [ADDR_W-1:0]   pix_idx;
   logic                advance;
   logic [COORD_W-1:0]  dx, dy;
   logic [15:0]         r_sq;
   logic [TENTH_W:0]    rem_sum;
   logic [16:0]         aa_next;
   logic [17:0]         ab_sum;
   logic [16:0]         bb_dec;
   logic [COORD_W-1:0]  mask;
   logic [24:0]         k_prod;
   logic [COORD_W-1:0]  k_whole;
   logic [DIV_W-1:0]    k_rest;

   function automatic logic [ADDR_W-1:0] store_index(input logic [COORD_W-1:0] col,
                                                     input logic [COORD_W-1:0] pg);
      return ADDR_W'(32'(col) * PAGE_COUNT + 32'(pg));
   endfunction

   mfbde_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Select the pixel the walker points at
   always_comb begin
      pix_x = x0_ff;
      pix_y = y0_ff;
      unique case (kind_ff)
         KIND_SET, KIND_CLR: begin
            pix_x = x0_ff;
            pix_y = y0_ff;
         end
         KIND_VERT: begin
            pix_x = x0_ff;
            pix_y = y0_ff + cnt_ff;
         end
         KIND_HORZ: begin
            pix_x = x0_ff + cnt_ff;
            pix_y = y0_ff;
         end
         KIND_DIAG: begin
            pix_x = x0_ff + cnt_ff;
            pix_y = y0_ff + q_ff;
         end
         KIND_CIRC: begin
            unique case (oct_ff)
               3'd0: begin pix_x = x0_ff + a_ff; pix_y = y0_ff - b_ff; end
               3'd1: begin pix_x = x0_ff - a_ff; pix_y = y0_ff - b_ff; end
               3'd2: begin pix_x = x0_ff - a_ff; pix_y = y0_ff + b_ff; end
               3'd3: begin pix_x = x0_ff + a_ff; pix_y = y0_ff + b_ff; end
               3'd4: begin pix_x = x0_ff + b_ff; pix_y = y0_ff + a_ff; end
               3'd5: begin pix_x = x0_ff + b_ff; pix_y = y0_ff - a_ff; end
               3'd6: begin pix_x = x0_ff - b_ff; pix_y = y0_ff - a_ff; end
               3'd7: begin pix_x = x0_ff - b_ff; pix_y = y0_ff + a_ff; end
               default: begin pix_x = x0_ff; pix_y = y0_ff; end
            endcase
         end
         default: begin
            pix_x = x0_ff;
            pix_y = y0_ff;
         end
      endcase
   end

   assign pix_on  = ({1'b0, pix_x} < 9'(PANEL_WIDTH)) && ({1'b0, pix_y} < 9'(PANEL_HEIGHT));
   assign pix_idx = store_index(pix_x, {3'b000, pix_y[7:3]});

   // Request decode helpers
   assign dx      = req_ch.x_end - req_ch.x;
   assign dy      = req_ch.y_end - req_ch.y;
   assign r_sq    = {8'b0, req_ch.radius} * {8'b0, req_ch.radius};

   // Split the slope into whole steps and tenths by reciprocal multiplication
   assign k_prod  = {13'b0, k_ff} * 25'(TENTH_RECIP);
   assign k_whole = k_prod[TENTH_SHIFT +: COORD_W];
   assign k_rest  = k_ff - ({1'b0, k_whole, 3'b000} + {3'b000, k_whole, 1'b0});

   // Step arithmetic for diagonal lines and circles
   assign rem_sum = {1'b0, rem_ff} + {1'b0, kr_ff};
   assign aa_next = {1'b0, aa_ff} + {8'b0, a_ff, 1'b0} + 17'd1;
   assign ab_sum  = {1'b0, aa_next} + {2'b00, bb_ff};
   assign bb_dec  = {1'b0, bb_ff} - {8'b0, b_ff, 1'b0} + 17'd1;
   assign mask    = COORD_W'(1) << pix_bit_ff;

   // Next state and datapath
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      cnt_in        = cnt_ff;
      len_in        = len_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      k_in          = k_ff;
      kq_in         = kq_ff;
      kr_in         = kr_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      aa_in         = aa_ff;
      bb_in         = bb_ff;
      rr_in         = rr_ff;
      oct_in        = oct_ff;
      pix_addr_in   = pix_addr_ff;
      pix_bit_in    = pix_bit_ff;
      clr_cnt_in    = clr_cnt_ff;
      st_in         = st_ff;
      rd_in         = rd_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mem_raddr     = pix_idx;
      mem_waddr     = clr_cnt_ff;
      mem_wdata     = '0;
      mem_we        = 1'b0;
      div_req       = '0;
      advance       = 1'b0;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         // Sweep zeros through the store
         S_INIT, S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               clr_cnt_in = '0;
               state_in   = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end

         // Accept a transaction and set up the walker
         S_IDLE: begin
            req_ch.ready = 1'b1;
            mem_raddr    = store_index(req_ch.x, req_ch.y);
            if (req_ch.valid) begin
               x0_in  = req_ch.x;
               y0_in  = req_ch.y;
               cnt_in = '0;
               st_in  = 1'b0;
               rd_in  = '0;
               unique case (op_type'(req_ch.op))
                  OP_SET_POINT: begin
                     kind_in  = KIND_SET;
                     state_in = S_PIX;
                  end
                  OP_CLEAR_POINT: begin
                     kind_in  = KIND_CLR;
                     state_in = S_PIX;
                  end
                  OP_LINE: begin
                     if (({1'b0, req_ch.x_end} > 9'(PANEL_WIDTH)) ||
                         ({1'b0, req_ch.y_end} > 9'(PANEL_HEIGHT)) ||
                         (req_ch.x > req_ch.x_end) || (req_ch.y > req_ch.y_end)) begin
                        st_in    = 1'b1;
                        state_in = S_DONE;
                     end else if (dx == '0) begin
                        kind_in  = KIND_VERT;
                        len_in   = dy;
                        state_in = (dy == '0) ? S_DONE : S_PIX;
                     end else if (dy == '0) begin
                        kind_in  = KIND_HORZ;
                        len_in   = dx;
                        state_in = S_PIX;
                     end else begin
                        kind_in       = KIND_DIAG;
                        len_in        = dx;
                        div_req.start = 1'b1;
                        div_req.num   = {1'b0, dy, 3'b000} + {3'b000, dy, 1'b0};
                        div_req.den   = {4'b0000, dx};
                        state_in      = S_DIV_K;
                     end
                  end
                  OP_CIRCLE: begin
                     if (req_ch.radius == '0) begin
                        kind_in  = KIND_SET;
                        state_in = S_PIX;
                     end else begin
                        kind_in  = KIND_CIRC;
                        a_in     = '0;
                        b_in     = req_ch.radius;
                        aa_in    = '0;
                        bb_in    = r_sq;
                        rr_in    = r_sq;
                        oct_in   = '0;
                        state_in = S_CIR_TEST;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  OP_READ_BYTE: begin
                     if (({1'b0, req_ch.x} < 9'(PANEL_WIDTH)) &&
                         ({1'b0, req_ch.y} < 9'(PAGE_COUNT))) begin
                        state_in = S_RDWAIT;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // Slope in tenths, then split it into whole part and tenths
         S_DIV_K: begin
            if (div_rsp.done) begin
               k_in     = div_rsp.quot;
               state_in = S_DIV_T;
            end
         end
         S_DIV_T: begin
            kq_in    = k_whole;
            kr_in    = k_rest[TENTH_W-1:0];
            q_in     = '0;
            rem_in   = '0;
            state_in = S_PIX;
         end

         // Keep plotting while the circle stays in its first octant
         S_CIR_TEST: begin
            state_in = ({bb_ff, 1'b0} >= {1'b0, rr_ff}) ? S_PIX : S_DONE;
         end
         S_CIR_STEP: begin
            if (ab_sum > {2'b00, rr_ff}) begin
               b_in  = b_ff - 1'b1;
               bb_in = bb_dec[15:0];
            end else begin
               a_in  = a_ff + 1'b1;
               aa_in = aa_next[15:0];
            end
            state_in = S_CIR_TEST;
         end

         // Read the byte under the pixel, or skip pixels off the panel
         S_PIX: begin
            mem_raddr = pix_idx;
            if (pix_on) begin
               pix_addr_in = pix_idx;
               pix_bit_in  = pix_y[2:0];
               state_in    = S_WRITE;
            end else begin
               advance = 1'b1;
            end
         end

         // Write back the modified byte
         S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr_ff;
            mem_wdata = (kind_ff == KIND_CLR) ? (mem_rdata_ff & ~mask) : (mem_rdata_ff | mask);
            advance   = 1'b1;
         end

         S_RDWAIT: begin
            rd_in    = mem_rdata_ff;
            state_in = S_DONE;
         end

         // Hand the result to the response register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_data_in   = rd_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Move the walker to its next pixel
      if (advance) begin
         unique case (kind_ff)
            KIND_SET, KIND_CLR: state_in = S_DONE;
            KIND_VERT, KIND_HORZ, KIND_DIAG: begin
               if (cnt_ff == len_ff - 1'b1) begin
                  state_in = S_DONE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_PIX;
                  if (rem_sum >= (TENTH_W + 1)'(SLOPE_SCALE)) begin
                     rem_in = TENTH_W'(rem_sum - (TENTH_W + 1)'(SLOPE_SCALE));
                     q_in   = q_ff + kq_ff + 1'b1;
                  end else begin
                     rem_in = rem_sum[TENTH_W-1:0];
                     q_in   = q_ff + kq_ff;
                  end
               end
            end
            KIND_CIRC: begin
               oct_in   = oct_ff + 1'b1;
               state_in = (oct_ff == 3'd7) ? S_CIR_STEP : S_PIX;
            end
            default: state_in = S_DONE;
         endcase
      end
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      cnt_ff        <= cnt_in;
      len_ff        <= len_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      k_ff          <= k_in;
      kq_ff         <= kq_in;
      kr_ff         <= kr_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      aa_ff         <= aa_in;
      bb_ff         <= bb_in;
      rr_ff         <= rr_in;
      oct_ff        <= oct_in;
      pix_addr_ff   <= pix_addr_in;
      pix_bit_ff    <= pix_bit_in;
      st_ff         <= st_in;
      rd_ff         <= rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Frame memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= frame_mem[mem_raddr];
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.read_data = rsp_data_ff;

   // Reset always starts the clearing pass
   a_reset_clear: assert property (@(posedge clock)
      reset |=> state_ff == S_INIT)
      else $error("reset did not start the clearing pass");

   // No request taken while the store is being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT || state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("request accepted during clear");

   // Memory writes come only from the clear sweep or a pixel write-back
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_WRITE || state_ff == S_INIT || state_ff == S_CLEAR))
      else $error("unexpected memory write");

   // A write-back always follows the read of its byte
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> $past(state_ff) == S_PIX)
      else $error("write-back without a preceding read");

endmodule
